// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- rtl/core/tdl_pkg.sv -----
// ---------------------------------------------------------------------------
// tdl_pkg
// Types and constants of the two-wire display bus listener.
// ---------------------------------------------------------------------------
`default_nettype none

package tdl_pkg;

    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;

    localparam logic [BYTE_W-1:0] KEY_BIT_MASK = 8'h80;

    localparam logic [BYTE_W-1:0] KEY_READ_CMD_RST     = 8'h4F;
    localparam logic [BYTE_W-1:0] DIGIT_ONE_ADDR_RST   = 8'h68;
    localparam logic [BYTE_W-1:0] DIGIT_TWO_ADDR_RST   = 8'h6A;
    localparam logic [BYTE_W-1:0] DIGIT_THREE_ADDR_RST = 8'h6C;

    localparam logic [CNT_W-1:0] CNT_BYTE_DONE = 4'd8;
    localparam logic [CNT_W-1:0] CNT_ACK_DONE  = 4'd9;
    localparam logic [CNT_W-1:0] CNT_MAX       = 4'd15;
    localparam logic [CNT_W-1:0] BITS_KEY_DONE = 4'd8;
    localparam logic [CNT_W-1:0] BITS_RELEASED = 4'd9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_READ_CMD     = 8'd0,
        CFG_DIGIT_ONE_ADDR   = 8'd1,
        CFG_DIGIT_TWO_ADDR   = 8'd2,
        CFG_DIGIT_THREE_ADDR = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] digit_three_addr;
        logic [BYTE_W-1:0] digit_two_addr;
        logic [BYTE_W-1:0] digit_one_addr;
        logic [BYTE_W-1:0] key_read_cmd;
    } cfg_t;

    typedef struct packed {
        logic              hold_off;
        logic [BYTE_W-1:0] key_code;
        logic              sda;
        logic              scl;
    } sample_t;

    typedef struct packed {
        logic              in_frame;
        logic              key_reply_active;
        logic [BYTE_W-1:0] digit_three;
        logic [BYTE_W-1:0] digit_two;
        logic [BYTE_W-1:0] digit_one;
        logic              sda_level;
        logic              sda_drive;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/tdl_core.sv -----
// ---------------------------------------------------------------------------
// tdl_core
// Bus protocol state: START/STOP detection, byte shifter, ACK and key reply.
// Advances one sample when step_en is high; result is the updated state.
// ---------------------------------------------------------------------------
`default_nettype none

module tdl_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step_en,
    input  wire tdl_pkg::sample_t sample,
    input  wire tdl_pkg::cfg_t    cfg,
    output tdl_pkg::result_t      result
);

    logic                       last_sda_reg, last_sda_next;
    logic                       held_sda_reg, held_sda_next;
    logic                       last_scl_reg, last_scl_next;
    logic                       receiving_reg, receiving_next;
    logic                       second_byte_reg, second_byte_next;
    logic                       acking_reg, acking_next;
    logic                       replying_reg, replying_next;
    logic [tdl_pkg::CNT_W-1:0]  clock_count_reg, clock_count_next;
    logic [tdl_pkg::CNT_W-1:0]  bits_sent_reg, bits_sent_next;
    logic [tdl_pkg::BYTE_W-1:0] shift_byte_reg, shift_byte_next;
    logic [tdl_pkg::BYTE_W-1:0] first_byte_reg, first_byte_next;
    logic [tdl_pkg::BYTE_W-1:0] digit_one_reg, digit_one_next;
    logic [tdl_pkg::BYTE_W-1:0] digit_two_reg, digit_two_next;
    logic [tdl_pkg::BYTE_W-1:0] digit_three_reg, digit_three_next;
    logic                       drive_enable_reg, drive_enable_next;
    logic                       drive_level_reg, drive_level_next;

    always_comb
    begin
        logic [tdl_pkg::BYTE_W-1:0] shifted;

        last_sda_next     = last_sda_reg;
        held_sda_next     = held_sda_reg;
        last_scl_next     = last_scl_reg;
        receiving_next    = receiving_reg;
        second_byte_next  = second_byte_reg;
        acking_next       = acking_reg;
        replying_next     = replying_reg;
        clock_count_next  = clock_count_reg;
        bits_sent_next    = bits_sent_reg;
        shift_byte_next   = shift_byte_reg;
        first_byte_next   = first_byte_reg;
        digit_one_next    = digit_one_reg;
        digit_two_next    = digit_two_reg;
        digit_three_next  = digit_three_reg;
        drive_enable_next = drive_enable_reg;
        drive_level_next  = drive_level_reg;
        shifted           = sample.key_code << bits_sent_reg[2:0];

        if (sample.hold_off)
        begin
            receiving_next    = 1'b0;
            second_byte_next  = 1'b1;
            acking_next       = 1'b0;
            replying_next     = 1'b0;
            clock_count_next  = '0;
            bits_sent_next    = '0;
            shift_byte_next   = '0;
            drive_enable_next = 1'b0;
            drive_level_next  = 1'b1;
            last_sda_next     = sample.sda;
            held_sda_next     = sample.sda;
            last_scl_next     = sample.scl;
        end
        else
        begin
            // data sample frozen while driving the line
            if (!replying_reg && !acking_reg)
                held_sda_next = sample.sda;

            priority if (sample.scl && last_sda_reg && !held_sda_next)
            begin
                receiving_next   = 1'b1;
                second_byte_next = 1'b0;
            end
            else if (sample.scl && !last_sda_reg && held_sda_next)
            begin
                receiving_next   = 1'b0;
                replying_next    = 1'b0;
                second_byte_next = 1'b0;
                clock_count_next = '0;
                shift_byte_next  = '0;
            end
            else if (!last_scl_reg && sample.scl && receiving_reg)
            begin
                if (!replying_reg)
                begin
                    if (clock_count_reg < tdl_pkg::CNT_BYTE_DONE)
                        shift_byte_next = {shift_byte_reg[tdl_pkg::BYTE_W-2:0],
                                           held_sda_next};
                    else
                    begin
                        if (!second_byte_reg)
                        begin
                            first_byte_next = shift_byte_reg;
                            if (shift_byte_reg == cfg.key_read_cmd)
                            begin
                                replying_next    = 1'b1;
                                second_byte_next = 1'b1;
                            end
                        end
                        else
                        begin
                            priority if (first_byte_reg == cfg.digit_one_addr)
                                digit_one_next = shift_byte_reg;
                            else if (first_byte_reg == cfg.digit_two_addr)
                                digit_two_next = shift_byte_reg;
                            else if (first_byte_reg == cfg.digit_three_addr)
                                digit_three_next = shift_byte_reg;
                            else
                                digit_three_next = digit_three_reg;
                        end
                        shift_byte_next  = '0;
                        second_byte_next = ~second_byte_next;
                    end
                    if (clock_count_reg < tdl_pkg::CNT_MAX)
                        clock_count_next = clock_count_reg + 1'b1;
                end
            end
            else if (last_scl_reg && !sample.scl && receiving_reg)
            begin
                if (clock_count_reg == tdl_pkg::CNT_BYTE_DONE && !replying_reg)
                begin
                    drive_enable_next = 1'b1;
                    drive_level_next  = 1'b0;
                    acking_next       = 1'b1;
                end
                else if (acking_reg && clock_count_reg == tdl_pkg::CNT_ACK_DONE)
                begin
                    if (!replying_reg)
                    begin
                        drive_enable_next = 1'b0;
                        drive_level_next  = 1'b1;
                    end
                    acking_next      = 1'b0;
                    clock_count_next = '0;
                end
                if (replying_reg)
                begin
                    priority if (bits_sent_reg < tdl_pkg::BITS_KEY_DONE)
                    begin
                        drive_level_next = |(shifted & tdl_pkg::KEY_BIT_MASK);
                        bits_sent_next   = bits_sent_reg + 1'b1;
                    end
                    else if (bits_sent_reg == tdl_pkg::BITS_KEY_DONE)
                    begin
                        drive_enable_next = 1'b0;
                        drive_level_next  = 1'b1;
                        bits_sent_next    = tdl_pkg::BITS_RELEASED;
                    end
                    else
                    begin
                        replying_next  = 1'b0;
                        bits_sent_next = '0;
                    end
                end
            end
            else
                receiving_next = receiving_reg;

            if (!replying_next)
                last_sda_next = held_sda_next;
            last_scl_next = sample.scl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sda_reg     <= 1'b1;
            held_sda_reg     <= 1'b1;
            last_scl_reg     <= 1'b0;
            receiving_reg    <= 1'b0;
            second_byte_reg  <= 1'b0;
            acking_reg       <= 1'b0;
            replying_reg     <= 1'b0;
            clock_count_reg  <= '0;
            bits_sent_reg    <= '0;
            shift_byte_reg   <= '0;
            first_byte_reg   <= '0;
            digit_one_reg    <= '0;
            digit_two_reg    <= '0;
            digit_three_reg  <= '0;
            drive_enable_reg <= 1'b0;
            drive_level_reg  <= 1'b1;
        end
        else if (step_en)
        begin
            last_sda_reg     <= last_sda_next;
            held_sda_reg     <= held_sda_next;
            last_scl_reg     <= last_scl_next;
            receiving_reg    <= receiving_next;
            second_byte_reg  <= second_byte_next;
            acking_reg       <= acking_next;
            replying_reg     <= replying_next;
            clock_count_reg  <= clock_count_next;
            bits_sent_reg    <= bits_sent_next;
            shift_byte_reg   <= shift_byte_next;
            first_byte_reg   <= first_byte_next;
            digit_one_reg    <= digit_one_next;
            digit_two_reg    <= digit_two_next;
            digit_three_reg  <= digit_three_next;
            drive_enable_reg <= drive_enable_next;
            drive_level_reg  <= drive_level_next;
        end
    end

    assign result.sda_drive        = drive_enable_next;
    assign result.sda_level        = drive_level_next;
    assign result.digit_one        = digit_one_next;
    assign result.digit_two        = digit_two_next;
    assign result.digit_three      = digit_three_next;
    assign result.key_reply_active = replying_next;
    assign result.in_frame         = receiving_next;

endmodule

`default_nettype wire

// ----- rtl/core/two_wire_display_bus_listener_top.sv -----
// ---------------------------------------------------------------------------
// two_wire_display_bus_listener_top
// Two-wire display bus listener: one line sample in, one status word out.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample request per cycle of the bus lines (scl, sda),
//   the key code to answer with and the hold-off flag.
//   m_axis returns one result per sample: line drive, the three digit
//   registers, key reply and frame flags, all after the sample is applied.
//   cfg writes the four address/command registers; cfg_ready is always high.
//   It is up to the user that writes go in only while no sample is in flight;
//   the block does not enforce it. Path: input register, protocol update,
//   result register. Throughput: one sample per cycle unless m_axis stalls,
//   set by the combinational protocol update between those registers.
//   Reset: protocol state cleared, line released, registers to defaults,
//   both pipeline stages empty.
//   Stall: with m_axis_tready low the result holds; one more sample is taken
//   into the input register, then s_axis_tready drops until the result
//   is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module two_wire_display_bus_listener_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // scl[0], sda[1], key_code[9:2], hold_off[10], zero[15:11]
    input  wire logic [tdl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // sda_drive[0], sda_level[1], digit_one[9:2], digit_two[17:10],
    // digit_three[25:18], key_reply_active[26], in_frame[27], zero[31:28]
    output logic [tdl_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tdl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tdl_pkg::BYTE_W-1:0]        cfg_data
);

    localparam int SAMPLE_W = $bits(tdl_pkg::sample_t);
    localparam int RESULT_W = $bits(tdl_pkg::result_t);

    tdl_pkg::cfg_t    cfg_reg;
    tdl_pkg::sample_t in_data_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    tdl_pkg::result_t out_data_reg;
    tdl_pkg::result_t step_result;
    logic             advance;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_read_cmd     <= tdl_pkg::KEY_READ_CMD_RST;
            cfg_reg.digit_one_addr   <= tdl_pkg::DIGIT_ONE_ADDR_RST;
            cfg_reg.digit_two_addr   <= tdl_pkg::DIGIT_TWO_ADDR_RST;
            cfg_reg.digit_three_addr <= tdl_pkg::DIGIT_THREE_ADDR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (tdl_pkg::cfg_index_t'(cfg_index))
                tdl_pkg::CFG_KEY_READ_CMD:     cfg_reg.key_read_cmd     <= cfg_data;
                tdl_pkg::CFG_DIGIT_ONE_ADDR:   cfg_reg.digit_one_addr   <= cfg_data;
                tdl_pkg::CFG_DIGIT_TWO_ADDR:   cfg_reg.digit_two_addr   <= cfg_data;
                tdl_pkg::CFG_DIGIT_THREE_ADDR: cfg_reg.digit_three_addr <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_data_reg <= tdl_pkg::sample_t'(s_axis_tdata[SAMPLE_W-1:0]);
        if (advance)
            out_data_reg <= step_result;
    end

    tdl_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .sample  (in_data_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(tdl_pkg::OUT_DATA_W - RESULT_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

// ----- rtl/core/tdl_checker.sv -----
// ---------------------------------------------------------------------------
// tdl_checker
// Port-level checks of the two-wire display bus listener, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tdl_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [tdl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [tdl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    tdl_pkg::result_t res;
    logic             in_wait;
    logic             out_wait;
    logic             reply_out;

    assign res       = tdl_pkg::result_t'(m_axis_tdata[$bits(tdl_pkg::result_t)-1:0]);
    assign in_wait   = s_axis_tvalid && !s_axis_tready;
    assign out_wait  = m_axis_tvalid && !m_axis_tready;
    assign reply_out = m_axis_tvalid && res.key_reply_active;

    // stalled result holds
    `ASSERT_CLKD(a_out_hold, clk, rst_n, out_wait |=> m_axis_tvalid && $stable(m_axis_tdata))
    // waiting request holds
    `ASSERT_CLKD(a_in_hold, clk, rst_n, in_wait |=> s_axis_tvalid && $stable(s_axis_tdata))
    // input side only backs up behind a stalled result
    `ASSERT_CLKD(a_ready_stall, clk, rst_n, !s_axis_tready |-> out_wait)
    // a key reply only runs inside a frame
    `ASSERT_CLKD(a_reply_in_frame, clk, rst_n, reply_out |-> res.in_frame)
    // nothing offered during reset
    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !m_axis_tvalid)

endmodule

bind two_wire_display_bus_listener_top tdl_checker u_tdl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Bus-level check of the two-wire display bus listener. Line samples are fed
// one per request, each status word out is compared field by field with a
// cycle model kept in the bench. START/STOP, byte writes to each digit,
// key reads, hold-off and line noise run under several address settings,
// with random gaps on both streams.
// ---------------------------------------------------------------------------

module tb_top;

    localparam int  RES_W = $bits(tdl_pkg::result_t);
    localparam int  SMP_W = $bits(tdl_pkg::sample_t);
    localparam bit  PREDICT = 1'b0;
    localparam bit  FIXED   = 1'b1;
    localparam logic [tdl_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'hFF;

    localparam tdl_pkg::result_t NO_RES = '0;
    localparam tdl_pkg::result_t IDLE_RES = '{in_frame: 1'b0, key_reply_active: 1'b0,
                                     digit_three: 8'h00, digit_two: 8'h00,
                                     digit_one: 8'h00, sda_level: 1'b1, sda_drive: 1'b0};
    localparam tdl_pkg::result_t FRAME_RES = '{in_frame: 1'b1, key_reply_active: 1'b0,
                                      digit_three: 8'h00, digit_two: 8'h00,
                                      digit_one: 8'h00, sda_level: 1'b1, sda_drive: 1'b0};

    typedef struct {
        logic              scl;
        logic              sda;
        logic [7:0]        key;
        logic              hold;
        bit                kind;
        tdl_pkg::result_t  res;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b1;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tdl_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [tdl_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tdl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tdl_pkg::BYTE_W-1:0]      cfg_data = '0;

    two_wire_display_bus_listener_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // listener model state
    logic       sda_prev = 1'b1;
    logic       sda_hold = 1'b1;
    logic       scl_prev = 1'b0;
    logic       rx_busy = 1'b0;
    logic       data_phase = 1'b0;
    logic       ack_on = 1'b0;
    logic       key_on = 1'b0;
    logic [3:0] clk_cnt = '0;
    logic [3:0] key_bits = '0;
    logic [7:0] rx_shift = '0;
    logic [7:0] addr_byte = '0;
    logic [7:0] digits [3] = '{8'h00, 8'h00, 8'h00};
    logic       drv_en = 1'b0;
    logic       drv_lvl = 1'b1;
    logic [7:0] key_cmd_r = tdl_pkg::KEY_READ_CMD_RST;
    logic [7:0] digit_addr_r [3] = '{tdl_pkg::DIGIT_ONE_ADDR_RST,
                                     tdl_pkg::DIGIT_TWO_ADDR_RST,
                                     tdl_pkg::DIGIT_THREE_ADDR_RST};

    tdl_pkg::result_t status_due [$];
    tdl_pkg::result_t got_res;
    tdl_pkg::result_t want_res;
    int         errors = 0;
    int         n_samples = 0;
    int         n_results = 0;
    int         n_writes = 0;
    int         n_reads = 0;
    int         n_settings = 0;
    bit         tx_quiet = 1'b0;
    bit         rx_quiet = 1'b0;
    logic [7:0] cur_key = '0;

    stim_row_t dir_rows [19] = '{
        '{1'b1, 1'b1, 8'h00, 1'b0, FIXED,   IDLE_RES},   // out of reset, bus idle
        '{1'b0, 1'b0, 8'hFF, 1'b1, FIXED,   IDLE_RES},   // hold-off
        '{1'b1, 1'b1, 8'h00, 1'b1, FIXED,   IDLE_RES},
        '{1'b1, 1'b1, 8'hAA, 1'b0, FIXED,   IDLE_RES},
        '{1'b1, 1'b0, 8'h55, 1'b0, FIXED,   FRAME_RES},  // START
        '{1'b0, 1'b0, 8'h55, 1'b0, PREDICT, NO_RES},
        '{1'b1, 1'b1, 8'h55, 1'b0, FIXED,   IDLE_RES},   // STOP
        '{1'b1, 1'b0, 8'h00, 1'b0, FIXED,   FRAME_RES},  // START
        '{1'b0, 1'b1, 8'h00, 1'b1, FIXED,   IDLE_RES},   // hold-off inside a frame
        '{1'b1, 1'b1, 8'h0F, 1'b0, PREDICT, NO_RES},
        '{1'b1, 1'b0, 8'hF0, 1'b0, PREDICT, NO_RES},
        '{1'b0, 1'b1, 8'hF0, 1'b0, PREDICT, NO_RES},
        '{1'b1, 1'b1, 8'hF0, 1'b0, PREDICT, NO_RES},
        '{1'b0, 1'b0, 8'hF0, 1'b0, PREDICT, NO_RES},
        '{1'b1, 1'b0, 8'hF0, 1'b0, PREDICT, NO_RES},
        '{1'b1, 1'b1, 8'hF0, 1'b0, PREDICT, NO_RES},     // STOP after two bits
        '{1'b0, 1'b0, 8'hFF, 1'b1, FIXED,   IDLE_RES},
        '{1'b1, 1'b0, 8'h00, 1'b1, FIXED,   IDLE_RES},
        '{1'b1, 1'b1, 8'h00, 1'b0, PREDICT, NO_RES}
    };

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("[two_wire_display_bus_listener_top] ERROR");
        $finish;
    end

    function automatic tdl_pkg::sample_t make_sample(input logic scl, input logic sda,
                                                     input logic [7:0] key,
                                                     input logic hold);
        tdl_pkg::sample_t s;
        s.scl      = scl;
        s.sda      = sda;
        s.key_code = key;
        s.hold_off = hold;
        return s;
    endfunction

    // Listener model advanced by one sample; state lives at module level.
    function automatic tdl_pkg::result_t next_status(input tdl_pkg::sample_t s);
        tdl_pkg::result_t r;
        if (s.hold_off) begin
            rx_busy    = 1'b0;
            data_phase = 1'b1;
            ack_on     = 1'b0;
            key_on     = 1'b0;
            clk_cnt    = '0;
            key_bits   = '0;
            rx_shift   = '0;
            drv_en     = 1'b0;
            drv_lvl    = 1'b1;
            sda_prev   = s.sda;
            sda_hold   = s.sda;
            scl_prev   = s.scl;
        end
        else begin
            if (!key_on && !ack_on)
                sda_hold = s.sda;
            if (s.scl && sda_prev && !sda_hold) begin
                rx_busy    = 1'b1;
                data_phase = 1'b0;
            end
            else if (s.scl && !sda_prev && sda_hold) begin
                rx_busy    = 1'b0;
                key_on     = 1'b0;
                data_phase = 1'b0;
                clk_cnt    = '0;
                rx_shift   = '0;
            end
            else if (!scl_prev && s.scl && rx_busy) begin
                if (!key_on) begin
                    if (clk_cnt < tdl_pkg::CNT_BYTE_DONE)
                        rx_shift = {rx_shift[6:0], sda_hold};
                    else begin
                        if (!data_phase) begin
                            addr_byte = rx_shift;
                            if (rx_shift == key_cmd_r) begin
                                key_on     = 1'b1;
                                data_phase = 1'b1;
                            end
                        end
                        else if (addr_byte == digit_addr_r[0])
                            digits[0] = rx_shift;
                        else if (addr_byte == digit_addr_r[1])
                            digits[1] = rx_shift;
                        else if (addr_byte == digit_addr_r[2])
                            digits[2] = rx_shift;
                        rx_shift   = '0;
                        data_phase = !data_phase;
                    end
                    if (clk_cnt < tdl_pkg::CNT_MAX)
                        clk_cnt = clk_cnt + 4'd1;
                end
            end
            else if (scl_prev && !s.scl && rx_busy) begin
                if (clk_cnt == tdl_pkg::CNT_BYTE_DONE && !key_on) begin
                    drv_en  = 1'b1;
                    drv_lvl = 1'b0;
                    ack_on  = 1'b1;
                end
                else if (ack_on && clk_cnt == tdl_pkg::CNT_ACK_DONE) begin
                    if (!key_on) begin
                        drv_en  = 1'b0;
                        drv_lvl = 1'b1;
                    end
                    ack_on  = 1'b0;
                    clk_cnt = '0;
                end
                if (key_on) begin
                    if (key_bits < tdl_pkg::BITS_KEY_DONE) begin
                        drv_lvl  = |((s.key_code << key_bits) & tdl_pkg::KEY_BIT_MASK);
                        key_bits = key_bits + 4'd1;
                    end
                    else if (key_bits == tdl_pkg::BITS_KEY_DONE) begin
                        drv_en   = 1'b0;
                        drv_lvl  = 1'b1;
                        key_bits = tdl_pkg::BITS_RELEASED;
                    end
                    else begin
                        key_on   = 1'b0;
                        key_bits = '0;
                    end
                end
            end
            if (!key_on)
                sda_prev = sda_hold;
            scl_prev = s.scl;
        end
        r.sda_drive        = drv_en;
        r.sda_level        = drv_lvl;
        r.digit_one        = digits[0];
        r.digit_two        = digits[1];
        r.digit_three      = digits[2];
        r.key_reply_active = key_on;
        r.in_frame         = rx_busy;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= 40)
            $display("status %0d: %s is 0x%0h, predicted 0x%0h", n_results, what, got, want);
    endtask

    // Call right after a rising edge; returns at the edge that took the request.
    task automatic send_sample(input tdl_pkg::sample_t s, input bit kind = PREDICT,
                               input tdl_pkg::result_t fixed_res = '0);
        tdl_pkg::result_t predicted;
        if (!tx_quiet && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(tdl_pkg::IN_DATA_W-SMP_W){1'b0}}, s};
        do @(posedge clk); while (!s_axis_tready);
        predicted = next_status(s);
        status_due.push_back(kind == FIXED ? fixed_res : predicted);
        n_samples++;
    endtask

    task automatic line(input logic scl, input logic sda);
        int reps;
        reps = ($urandom_range(7) == 0) ? $urandom_range(2, 3) : 1;
        repeat (reps)
            send_sample(make_sample(scl, sda,
                        ($urandom_range(9) == 0) ? 8'($urandom) : cur_key, 1'b0));
    endtask

    task automatic bus_start();
        line(1'b0, 1'b1);
        line(1'b1, 1'b1);
        line(1'b1, 1'b0);
        line(1'b0, 1'b0);
    endtask

    task automatic bus_stop();
        line(1'b0, 1'b0);
        line(1'b1, 1'b0);
        line(1'b1, 1'b1);
    endtask

    task automatic bus_bit(input logic b);
        line(1'b0, b);
        line(1'b1, b);
    endtask

    // eight bits MSB first, then the acknowledge clock with the line released
    task automatic bus_byte(input logic [7:0] v);
        int k;
        for (k = 7; k >= 0; k--)
            bus_bit(v[k]);
        bus_bit(1'b1);
    endtask

    task automatic write_frame(input logic [7:0] addr, input logic [7:0] data);
        bus_start();
        bus_byte(addr);
        bus_byte(data);
        bus_stop();
        n_writes++;
    endtask

    task automatic key_read(input int clocks);
        bus_start();
        bus_byte(key_cmd_r);
        repeat (clocks) bus_bit(1'($urandom_range(1)));
        bus_stop();
        n_reads++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] key_cmd, input logic [7:0] a1,
                               input logic [7:0] a2, input logic [7:0] a3);
        logic [tdl_pkg::CFG_INDEX_W-1:0] idx [5];
        logic [7:0]                      val [5];
        int                              k;
        idx = '{tdl_pkg::CFG_KEY_READ_CMD, tdl_pkg::CFG_DIGIT_ONE_ADDR,
                tdl_pkg::CFG_DIGIT_TWO_ADDR, tdl_pkg::CFG_DIGIT_THREE_ADDR,
                CFG_UNUSED_INDEX};
        val = '{key_cmd, a1, a2, a3, ~key_cmd};
        for (k = 0; k < 5; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            case (idx[k])
                tdl_pkg::CFG_KEY_READ_CMD:     key_cmd_r       = val[k];
                tdl_pkg::CFG_DIGIT_ONE_ADDR:   digit_addr_r[0] = val[k];
                tdl_pkg::CFG_DIGIT_TWO_ADDR:   digit_addr_r[1] = val[k];
                tdl_pkg::CFG_DIGIT_THREE_ADDR: digit_addr_r[2] = val[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_traffic(input int count);
        int         stop_at;
        int         pick;
        int         k;
        logic [7:0] addr;
        stop_at = n_samples + count;
        while (n_samples < stop_at) begin
            cur_key = 8'($urandom);
            k = $urandom_range(4);
            addr = (k < 3) ? digit_addr_r[k] : ((k == 3) ? key_cmd_r : 8'($urandom));
            pick = $urandom_range(99);
            if (pick < 35)
                write_frame(addr, 8'($urandom));
            else if (pick < 55)
                key_read(($urandom_range(9) == 0) ? $urandom_range(0, 8) : 9);
            else if (pick < 65) begin
                // several bytes, sometimes a repeated START
                bus_start();
                repeat ($urandom_range(2, 4))
                    bus_byte($urandom_range(1) ? addr : 8'($urandom));
                if ($urandom_range(1)) begin
                    bus_start();
                    bus_byte(addr);
                end
                bus_stop();
            end
            else if (pick < 75) begin
                bus_start();
                repeat ($urandom_range(1, 12)) bus_bit(1'($urandom_range(1)));
                if ($urandom_range(1))
                    bus_stop();
            end
            else if (pick < 85) begin
                repeat ($urandom_range(1, 8))
                    send_sample(make_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                            8'($urandom), $urandom_range(7) == 0));
            end
            else if (pick < 93) begin
                // hold-off in the middle of a write
                bus_start();
                bus_byte(addr);
                repeat ($urandom_range(8)) bus_bit(1'($urandom_range(1)));
                repeat ($urandom_range(1, 2))
                    send_sample(make_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                            8'($urandom), 1'b1));
                bus_byte(8'($urandom));
                bus_stop();
            end
            else
                repeat ($urandom_range(1, 4)) line(1'b1, 1'b1);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else begin
            m_axis_tready <= rx_quiet || ($urandom_range(99) >= 15);
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = tdl_pkg::result_t'(m_axis_tdata[RES_W-1:0]);
                n_results++;
                if (status_due.size() == 0)
                    report_mismatch("status word with no request", 8'h00, 8'h00);
                else begin
                    want_res = status_due.pop_front();
                    if (got_res.sda_drive !== want_res.sda_drive)
                        report_mismatch("sda_drive", 8'(got_res.sda_drive),
                                        8'(want_res.sda_drive));
                    if (got_res.sda_level !== want_res.sda_level)
                        report_mismatch("sda_level", 8'(got_res.sda_level),
                                        8'(want_res.sda_level));
                    if (got_res.digit_one !== want_res.digit_one)
                        report_mismatch("digit_one", got_res.digit_one, want_res.digit_one);
                    if (got_res.digit_two !== want_res.digit_two)
                        report_mismatch("digit_two", got_res.digit_two, want_res.digit_two);
                    if (got_res.digit_three !== want_res.digit_three)
                        report_mismatch("digit_three", got_res.digit_three,
                                        want_res.digit_three);
                    if (got_res.key_reply_active !== want_res.key_reply_active)
                        report_mismatch("key_reply_active", 8'(got_res.key_reply_active),
                                        8'(want_res.key_reply_active));
                    if (got_res.in_frame !== want_res.in_frame)
                        report_mismatch("in_frame", 8'(got_res.in_frame),
                                        8'(want_res.in_frame));
                end
            end
        end
    end

    initial begin
        logic [7:0] x;
        logic [7:0] y;
        #1 rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_sample(make_sample(dir_rows[i].scl, dir_rows[i].sda, dir_rows[i].key,
                                    dir_rows[i].hold), dir_rows[i].kind, dir_rows[i].res);

        // every digit, extreme data, unmatched address, full and cut key reads
        cur_key = 8'hFF;
        write_frame(tdl_pkg::DIGIT_ONE_ADDR_RST, 8'hFF);
        write_frame(tdl_pkg::DIGIT_TWO_ADDR_RST, 8'h00);
        write_frame(tdl_pkg::DIGIT_THREE_ADDR_RST, 8'h81);
        write_frame(8'h00, 8'h5A);
        key_read(9);
        cur_key = 8'h00;
        key_read(9);
        cur_key = 8'hA5;
        key_read(4);
        drain();

        x = 8'($urandom);
        y = 8'($urandom);
        load_config(8'($urandom), x, y, 8'($urandom));
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_traffic(40);
        drain();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // all addresses equal, key command equal to them
        load_config(8'h00, 8'h00, 8'h00, 8'h00);
        run_traffic(10);
        drain();

        load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_traffic(10);
        drain();

        x = 8'($urandom);
        y = 8'($urandom);
        load_config(y, x, x, y);
        run_traffic(10);
        drain();

        load_config(tdl_pkg::KEY_READ_CMD_RST, tdl_pkg::DIGIT_ONE_ADDR_RST,
                    tdl_pkg::DIGIT_TWO_ADDR_RST, tdl_pkg::DIGIT_THREE_ADDR_RST);
        run_traffic(10);
        drain();
        repeat (4) @(posedge clk);

        $display("listener run: %0d line samples, %0d status words compared, %0d mismatches",
                 n_samples, n_results, errors);
        $display("bus traffic: %0d register writes, %0d key reads, %0d address settings",
                 n_writes, n_reads, n_settings);
        if (errors == 0)
            $display("[two_wire_display_bus_listener_top] OK");
        else
            $display("[two_wire_display_bus_listener_top] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tdl_pkg.sv
rtl/core/tdl_core.sv
rtl/core/two_wire_display_bus_listener_top.sv
rtl/core/tdl_checker.sv
verif/tb_top.sv
